>>> rtl/core/srcu_pkg.sv
// ----------------------------------------------------------------------------
// srcu_pkg
// Shared types and constants for the systematic resampling counts unit.
// ----------------------------------------------------------------------------
package srcu_pkg;

  localparam int unsigned MAX_PARTICLES = 4096;

  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned STEP_W   = 25;
  localparam int unsigned WEIGHT_W = 25;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned INDEX_W  = 12;
  localparam int unsigned SUM_W    = 26;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 25;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(512);
  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PARTICLE_COUNT = 2'd0,
    CFG_TARGET_STEP    = 2'd1
  } srcu_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_COUNT,
    ST_COMMIT
  } srcu_state_t;

  typedef struct packed {
    logic load;     // capture input item
    logic accum;    // add weight into the running sum, open run if idle
    logic iterate;  // one target compare step
    logic commit;   // write result register and advance run state
  } srcu_cmd_t;

  typedef struct packed {
    logic count_done;
    logic out_free;
  } srcu_sts_t;

endpackage

>>> rtl/core/srcu_ctrl.sv
// ----------------------------------------------------------------------------
// srcu_ctrl
// Sequencer: accept, accumulate, count targets, commit result.
// ----------------------------------------------------------------------------
module srcu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  srcu_pkg::srcu_sts_t sts,
  output srcu_pkg::srcu_cmd_t cmd
);
  import srcu_pkg::*;

  srcu_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = ST_COUNT;
      end
      ST_COUNT: begin
        cmd.iterate = 1'b1;
        if (sts.count_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // hold until the result register can take the transfer
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/srcu_datapath.sv
// ----------------------------------------------------------------------------
// srcu_datapath
// Run state, target compare loop, configuration and result registers.
// ----------------------------------------------------------------------------
module srcu_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  srcu_pkg::srcu_cmd_t                    cmd,
  output srcu_pkg::srcu_sts_t                    sts,
  input  logic                                   cfg_wr_en,
  input  logic [srcu_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [srcu_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic [srcu_pkg::WEIGHT_W-1:0]          in_weight,
  input  logic [srcu_pkg::OFFSET_W-1:0]          in_start_offset,
  input  logic                                   in_last,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [srcu_pkg::INDEX_W-1:0]           out_particle_index,
  output logic [srcu_pkg::COUNT_W-1:0]           out_copies,
  output logic                                   out_run_done
);
  import srcu_pkg::*;

  logic [COUNT_W-1:0]  pcount_r;
  logic [STEP_W-1:0]   step_r;

  logic [WEIGHT_W-1:0] weight_r;
  logic [OFFSET_W-1:0] offset_r;
  logic                last_r;

  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    target_r;
  logic [COUNT_W-1:0]  issued_r;
  logic [INDEX_W-1:0]  pos_r;
  logic                in_run_r;
  logic [COUNT_W-1:0]  copies_r;

  logic                out_valid_r;
  logic [INDEX_W-1:0]  out_index_r;
  logic [COUNT_W-1:0]  out_copies_r;
  logic                out_done_r;

  logic [COUNT_W-1:0]  eff_count;
  logic [COUNT_W-1:0]  remaining;
  logic                final_item;
  logic                hit;
  logic                step_zero;
  logic [SUM_W-1:0]    base_sum;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W:0]      target_wide;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r <= COUNT_RESET;
      step_r   <= STEP_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_PARTICLE_COUNT) begin
        pcount_r <= cfg_wdata[COUNT_W-1:0];
      end else if (cfg_index == CFG_TARGET_STEP) begin
        step_r <= cfg_wdata[STEP_W-1:0];
      end
    end
  end

  always_comb begin
    priority if (pcount_r == '0) begin
      eff_count = COUNT_W'(1);
    end else if (pcount_r > COUNT_W'(MAX_PARTICLES)) begin
      eff_count = COUNT_W'(MAX_PARTICLES);
    end else begin
      eff_count = pcount_r;
    end
  end

  assign remaining  = (issued_r < eff_count) ? (eff_count - issued_r) : '0;
  assign final_item = last_r || ({1'b0, pos_r} + COUNT_W'(1) >= eff_count);
  assign step_zero  = (step_r == '0);
  assign hit        = (copies_r < remaining) && (target_r <= sum_r);
  assign base_sum   = in_run_r ? sum_r : '0;
  assign sum_wide   = {1'b0, base_sum} + (SUM_W+1)'(weight_r);
  assign target_wide = {1'b0, target_r} + (SUM_W+1)'(step_r);

  // a target pushed past the sum range lies beyond any sum: stop there
  assign sts.count_done = final_item || !hit || step_zero || target_wide[SUM_W];
  assign sts.out_free   = !out_valid_r || !out_stall;

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      weight_r <= in_weight;
      offset_r <= in_start_offset;
      last_r   <= in_last;
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      target_r <= '0;
      issued_r <= '0;
      pos_r    <= '0;
      in_run_r <= 1'b0;
      copies_r <= '0;
    end else begin
      if (cmd.accum) begin
        sum_r    <= sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        copies_r <= '0;
        if (!in_run_r) begin
          target_r <= SUM_W'(offset_r);
          issued_r <= '0;
          pos_r    <= '0;
          in_run_r <= 1'b1;
        end
      end
      if (cmd.iterate) begin
        priority if (final_item || (hit && step_zero)) begin
          copies_r <= remaining;
        end else if (hit) begin
          // advance to the next target; saturate past the sum range
          copies_r <= copies_r + COUNT_W'(1);
          target_r <= target_wide[SUM_W] ? SUM_MAX : target_wide[SUM_W-1:0];
        end else begin
          copies_r <= copies_r;
        end
      end
      if (cmd.commit) begin
        issued_r <= issued_r + copies_r;
        if (final_item) begin
          in_run_r <= 1'b0;
        end else begin
          pos_r <= pos_r + INDEX_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_index_r  <= pos_r;
      out_copies_r <= copies_r;
      out_done_r   <= final_item;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_particle_index = out_index_r;
  assign out_copies         = out_copies_r;
  assign out_run_done       = out_done_r;

endmodule

>>> rtl/core/systematic_resampling_counts_unit.sv
// ----------------------------------------------------------------------------
// systematic_resampling_counts_unit
// Streaming systematic resampling: weight in, particle copy count out.
// ----------------------------------------------------------------------------
// Particle weights (unsigned Q1.24) arrive one per transfer in particle order;
// the first transfer of a run also carries the random start offset. Each
// weight is added to a saturating cumulative sum, and the block returns one
// result per weight: the particle index, how many targets
// (start_offset + i*target_step) fall at or below the sum, and a run_done flag
// on the final particle, which takes every target still left. An item passes
// from the input transfer through the accumulate step, the target compare
// loop and the commit, which waits while a previous result sits stalled in
// the output register. The loop ends when the next target lies above the sum,
// when the particle count is used up, on the final particle, on a zero step,
// or when a target runs past the sum range. The loop issues one target per
// cycle through a single add and compare. Input is stalled while an item is
// in flight, but a finished result waiting in the output register does not
// block the next input transfer. The user must write particle_count and
// target_step through the cfg port only while the block is idle; the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
module systematic_resampling_counts_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [srcu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srcu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [srcu_pkg::WEIGHT_W-1:0]       in_weight,
  input  logic [srcu_pkg::OFFSET_W-1:0]       in_start_offset,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [srcu_pkg::INDEX_W-1:0]        out_particle_index,
  output logic [srcu_pkg::COUNT_W-1:0]        out_copies,
  output logic                                out_run_done
);
  import srcu_pkg::*;

  srcu_cmd_t cmd;
  srcu_sts_t sts;

  // sequencer: one item at a time through accumulate, count, commit
  srcu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: run state, target loop, result register
  srcu_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_weight          (in_weight),
    .in_start_offset    (in_start_offset),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_particle_index (out_particle_index),
    .out_copies         (out_copies),
    .out_run_done       (out_run_done)
  );

  // an accepted item always stalls the input in the cycle after its transfer
  a_accept_then_busy : assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("input not stalled after transfer");

  // a new result only appears as the sequencer returns to idle
  a_result_at_idle : assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall
  ) else $error("result loaded while item in flight");

  // commit happens only after the count loop has finished
  a_commit_after_count : assert property (
    @(posedge clk) disable iff (!rst_n)
    cmd.commit |-> $past(sts.count_done) || $past(!cmd.iterate)
  ) else $error("commit without finished count");

endmodule
